[hdl/ppmp_pkg.sv]
// Package for the PPM stream parser: parse phases, state and result structs,
// character and code constants, and small byte classifiers.
// No dependencies; used by ppmp_step and ppm_image_stream_parser.
package ppmp_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC0     = 4'd0,
    PH_MAGIC1     = 4'd1,
    PH_MAGIC_TAIL = 4'd2,
    PH_GAP_W      = 4'd3,
    PH_TOK_W      = 4'd4,
    PH_GAP_H      = 4'd5,
    PH_TOK_H      = 4'd6,
    PH_GAP_M      = 4'd7,
    PH_TOK_M      = 4'd8,
    PH_RAW        = 4'd9,
    PH_GAP_PIX    = 4'd10,
    PH_TOK_PIX    = 4'd11,
    PH_DRAIN      = 4'd12
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_MAGIC      = 3'd1;
  localparam logic [2:0] ERR_NEG_WIDTH  = 3'd2;
  localparam logic [2:0] ERR_NEG_HEIGHT = 3'd3;
  localparam logic [2:0] ERR_MAXVAL     = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd5;

  // characters
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [15:0] TOKEN_SAT = 16'hFFFF;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] accum;
    logic        neg;
    logic        digits_done;
    logic        in_comment;
    logic        fmt_bin;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] pix_left;
    logic [1:0]  chan;
    logic [7:0]  held_r;
    logic [7:0]  held_g;
  } st_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic        bin;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        done;
  } res_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b inside {CH_SP, [CH_TAB:CH_CR]};
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[CH_0:CH_9]};
  endfunction

endpackage

[hdl/ppm_image_stream_parser.sv]
// Top level of the PPM (P3/P6) byte stream parser: handshakes, parser state
// register, config register and result register. Depends on ppmp_pkg, ppmp_step.
//
// A result is registered and presented on out_tvalid in the cycle after its byte transfer.
// Throughput: one byte per cycle unless out_tready stalls a pending result; the result
// register refills in the cycle it drains. Reset (rst_n low, synchronous): parser back
// to the first magic byte, required maxval 255, no result pending.
module ppm_image_stream_parser #(
  parameter int MAX_DIM = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,     // required_maxval
  // byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  input  logic        in_tlast,     // last_byte
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,    // [2:0] fault_code, [3] is_binary, [19:4] image_width,
                                    // [35:20] image_height, [43:36] red, [51:44] green,
                                    // [59:52] blue, [63:60] zero
  output logic [1:0]  out_tuser,    // kind
  output logic        out_tlast     // image_done
);
  import ppmp_pkg::*;

  st_t        st_r;
  st_t        st_nxt;
  res_t       res_r;
  res_t       res_nxt;
  logic       res_vld_nxt;
  logic       out_valid_r;
  logic [7:0] req_maxval_r;
  logic       in_xfer;

  ppmp_step #(.MAX_DIM(MAX_DIM)) u_step (
    .st_i         (st_r),
    .byte_i       (in_tdata),
    .last_i       (in_tlast),
    .req_maxval_i (req_maxval_r),
    .st_o         (st_nxt),
    .vld_o        (res_vld_nxt),
    .res_o        (res_nxt)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      out_valid_r  <= 1'b0;
      req_maxval_r <= 8'd255;
    end else begin
      if (cfg_valid) req_maxval_r <= cfg_data;
      if (in_xfer) begin
        st_r        <= st_nxt;
        out_valid_r <= res_vld_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_vld_nxt) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.done;
  assign out_tdata  = {4'd0, res_r.blue, res_r.green, res_r.red, res_r.height,
                       res_r.width, res_r.bin, res_r.err};

endmodule

[hdl/ppmp_step.sv]
// Combinational next-state and result logic for one file byte of the parser.
// Depends on ppmp_pkg.
module ppmp_step #(
  parameter int MAX_DIM = 65535
) (
  input  ppmp_pkg::st_t  st_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  input  logic [7:0]     req_maxval_i,
  output ppmp_pkg::st_t  st_o,
  output logic           vld_o,
  output ppmp_pkg::res_t res_o
);
  import ppmp_pkg::*;

  localparam logic [15:0] MAX_DIM_W = 16'(MAX_DIM);

  typedef struct packed {
    st_t  st;
    logic vld;
    res_t res;
  } step_t;

  function automatic step_t put_error(input step_t x, input logic [2:0] code);
    step_t y;
    y = x;
    y.st.phase = PH_DRAIN;
    y.vld      = 1'b1;
    y.res      = '0;
    y.res.kind = KIND_ERROR;
    y.res.err  = code;
    y.res.bin  = x.st.fmt_bin;
    return y;
  endfunction

  function automatic step_t take_chan(input step_t x, input logic [7:0] v);
    step_t       y;
    logic [31:0] left;
    y = x;
    if (x.st.chan == 2'd0) begin
      y.st.held_r = v;
      y.st.chan   = 2'd1;
    end else if (x.st.chan == 2'd1) begin
      y.st.held_g = v;
      y.st.chan   = 2'd2;
    end else begin
      left = (x.st.pix_left != 32'd0) ? x.st.pix_left - 32'd1 : 32'd0;
      y.st.chan     = 2'd0;
      y.st.pix_left = left;
      if (left == 32'd0) y.st.phase = PH_DRAIN;
      y.vld       = 1'b1;
      y.res       = '0;
      y.res.kind  = KIND_PIXEL;
      y.res.bin   = x.st.fmt_bin;
      y.res.red   = x.st.held_r;
      y.res.green = x.st.held_g;
      y.res.blue  = v;
      y.res.done  = (left == 32'd0);
    end
    return y;
  endfunction

  function automatic logic [15:0] clamp_dim(input logic [15:0] v);
    return (v > MAX_DIM_W) ? MAX_DIM_W : v;
  endfunction

  function automatic step_t finish_tok(input step_t x, input logic [7:0] req);
    step_t       y;
    logic [15:0] mag;
    logic        neg;
    logic [7:0]  v;
    y   = x;
    mag = x.st.accum;
    neg = x.st.neg && (mag != 16'd0);
    v   = neg ? (8'd0 - mag[7:0]) : mag[7:0];
    y.st.accum       = '0;
    y.st.neg         = 1'b0;
    y.st.digits_done = 1'b0;
    case (x.st.phase)
      PH_TOK_W: begin
        if (neg) begin
          y = put_error(y, ERR_NEG_WIDTH);
        end else begin
          y.st.width = clamp_dim(mag);
          y.st.phase = PH_GAP_H;
        end
      end
      PH_TOK_H: begin
        if (neg) begin
          y = put_error(y, ERR_NEG_HEIGHT);
        end else begin
          y.st.height = clamp_dim(mag);
          y.st.phase  = PH_GAP_M;
        end
      end
      PH_TOK_M: begin
        if (neg || mag != {8'd0, req}) begin
          y = put_error(y, ERR_MAXVAL);
        end else begin
          y.st.pix_left = {16'd0, x.st.width} * {16'd0, x.st.height};
          y.st.chan     = 2'd0;
          y.vld         = 1'b1;
          y.res         = '0;
          y.res.kind    = KIND_HEADER;
          y.res.bin     = x.st.fmt_bin;
          y.res.width   = x.st.width;
          y.res.height  = x.st.height;
          // empty image: product is zero exactly when one side is zero
          if (x.st.width == 16'd0 || x.st.height == 16'd0) begin
            y.st.phase = PH_DRAIN;
            y.res.done = 1'b1;
          end else begin
            y.st.phase = x.st.fmt_bin ? PH_RAW : PH_GAP_PIX;
          end
        end
      end
      default: begin
        y.st.phase = PH_GAP_PIX;
        y = take_chan(y, v);
      end
    endcase
    return y;
  endfunction

  function automatic phase_t tok_of(input phase_t p);
    case (p)
      PH_GAP_W: return PH_TOK_W;
      PH_GAP_H: return PH_TOK_H;
      PH_GAP_M: return PH_TOK_M;
      default:  return PH_TOK_PIX;
    endcase
  endfunction

  step_t s;
  step_t t;
  logic  is_tok;
  logic  [19:0] acc10;

  always_comb begin
    s     = '0;
    s.st  = st_i;
    acc10 = {1'b0, st_i.accum, 3'b000} + {3'b000, st_i.accum, 1'b0} +
            {16'd0, byte_i[3:0]};
    case (st_i.phase)
      PH_MAGIC0: begin
        if (byte_i != CH_P) s = put_error(s, ERR_MAGIC);
        else s.st.phase = PH_MAGIC1;
      end
      PH_MAGIC1: begin
        if (byte_i == CH_3 || byte_i == CH_6) begin
          s.st.fmt_bin = (byte_i == CH_6);
          s.st.phase   = PH_MAGIC_TAIL;
        end else begin
          s = put_error(s, ERR_MAGIC);
        end
      end
      PH_MAGIC_TAIL: begin
        if (is_ws(byte_i)) s.st.phase = PH_GAP_W;
      end
      PH_GAP_W, PH_GAP_H, PH_GAP_M, PH_GAP_PIX: begin
        if (st_i.in_comment) begin
          if (byte_i == CH_LF) s.st.in_comment = 1'b0;
        end else if (is_ws(byte_i)) begin
          s.st.in_comment = 1'b0;
        end else if (byte_i == CH_HASH) begin
          s.st.in_comment = 1'b1;
        end else begin
          s.st.phase       = tok_of(st_i.phase);
          s.st.accum       = '0;
          s.st.neg         = (byte_i == CH_MINUS);
          s.st.digits_done = 1'b0;
          if (is_digit(byte_i)) begin
            s.st.accum = {12'd0, byte_i[3:0]};
          end else if (byte_i != CH_MINUS && byte_i != CH_PLUS) begin
            s.st.digits_done = 1'b1;
          end
        end
      end
      PH_TOK_W, PH_TOK_H, PH_TOK_M, PH_TOK_PIX: begin
        if (is_ws(byte_i)) begin
          s = finish_tok(s, req_maxval_i);
        end else if (!st_i.digits_done && is_digit(byte_i)) begin
          s.st.accum = (acc10 > {4'd0, TOKEN_SAT}) ? TOKEN_SAT : acc10[15:0];
        end else begin
          s.st.digits_done = 1'b1;
        end
      end
      PH_RAW: s = take_chan(s, byte_i);
      default: s.st.phase = PH_DRAIN;
    endcase

    // end of file: close an open token, flag truncation, restart
    t      = s;
    is_tok = (s.st.phase == PH_TOK_W) || (s.st.phase == PH_TOK_H) ||
             (s.st.phase == PH_TOK_M) || (s.st.phase == PH_TOK_PIX);
    if (last_i) begin
      if (st_i.phase != PH_DRAIN) begin
        if (!s.vld && is_tok) t = finish_tok(s, req_maxval_i);
        if (!(t.vld && (t.res.kind == KIND_ERROR || t.res.done))) begin
          t = put_error(t, ERR_TRUNCATED);
        end
      end
      t.st = '0;
    end
  end

  assign st_o  = t.st;
  assign vld_o = t.vld;
  assign res_o = t.res;

endmodule
